FILE: rtl/mrq_pkg.sv
// Package for the message ring queue: sizes, codes, shared types and helpers.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mrq_pkg;

   // Queue sizing
   localparam int SLOTS   = 16;
   localparam int MAX_LEN = 256;
   localparam int RING    = SLOTS + 1;

   // Derived widths
   localparam int SLOT_W = $clog2(RING);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int ADDR_W = $clog2(RING * MAX_LEN);
   localparam int CAP_W  = 9;
   localparam int CMP_W  = (LEN_W > CAP_W) ? LEN_W : CAP_W;

   // Depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0]        command_type;
   typedef logic [2:0]        status_type;
   typedef logic [7:0]        byte_type;
   typedef logic [CAP_W-1:0]  mlen_type;
   typedef logic [4:0]        qcount_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // Commands
   localparam command_type CMD_CLEAR = 2'd0;
   localparam command_type CMD_PUSH  = 2'd1;
   localparam command_type CMD_POP   = 2'd2;
   localparam command_type CMD_QUERY = 2'd3;

   // Result status codes
   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_COMMITTED = 3'd1;
   localparam status_type STATUS_TOO_LONG  = 3'd2;
   localparam status_type STATUS_EMPTY     = 3'd3;
   localparam status_type STATUS_TOO_SMALL = 3'd4;

   // One classified transaction, as handed from the front end to the back end
   typedef struct packed {
      logic       mem_wr;
      logic       mem_rd;
      addr_type   addr;
      byte_type   wdata;
      status_type status;
      logic       last;
      mlen_type   mlen;
      qcount_type qcount;
   } queue_entry_type;

   function automatic slot_type ring_next(input slot_type s);
      if (s == slot_type'(RING - 1)) begin
         return '0;
      end
      return s + slot_type'(1);
   endfunction

   function automatic addr_type slot_addr(input slot_type s, input pos_type p);
      return addr_type'(s) * addr_type'(MAX_LEN) + addr_type'(p);
   endfunction

endpackage

FILE: rtl/mrq_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on mrq_pkg for the payload types.
`timescale 1ns / 1ps

interface mrq_req_if;
   logic                 valid;
   logic                 ready;
   mrq_pkg::command_type command;
   mrq_pkg::byte_type    data_in;
   logic                 data_in_last;
   logic [8:0]           out_capacity;

   modport source (output valid, command, data_in, data_in_last, out_capacity,
                   input ready);
   modport sink   (input valid, command, data_in, data_in_last, out_capacity,
                   output ready);
endinterface

interface mrq_rsp_if;
   logic                 valid;
   logic                 ready;
   mrq_pkg::status_type  status;
   mrq_pkg::byte_type    data_out;
   logic                 data_out_last;
   mrq_pkg::mlen_type    message_length;
   mrq_pkg::qcount_type  queue_count;

   modport source (output valid, status, data_out, data_out_last, message_length,
                   queue_count, input ready);
   modport sink   (input valid, status, data_out, data_out_last, message_length,
                   queue_count, output ready);
endinterface

FILE: rtl/mrq_front.sv
// Front end: accepts request transactions, keeps the ring bookkeeping and
// classifies each transaction into a byte store access. Depends on mrq_pkg, mrq_if.
`timescale 1ns / 1ps

module mrq_front (
   input  logic                     clock,
   input  logic                     reset,
   mrq_req_if.sink                  req_chan,
   output logic                     q_push,
   input  logic                     q_ready,
   output mrq_pkg::queue_entry_type q_entry
);

   mrq_pkg::slot_type  head_ff, head_in;
   mrq_pkg::slot_type  tail_ff, tail_in;
   mrq_pkg::count_type count_ff, count_in;
   mrq_pkg::len_type   wpos_ff, wpos_in;
   mrq_pkg::pos_type   rpos_ff, rpos_in;
   logic               overlong_ff, overlong_in;

   mrq_pkg::len_type   slot_len_ff [mrq_pkg::RING];
   logic               len_wr;
   mrq_pkg::len_type   head_len;
   mrq_pkg::len_type   rpos_inc;
   logic               accept;

   assign accept         = req_chan.valid && q_ready;
   assign req_chan.ready = q_ready;
   assign q_push         = accept;
   assign head_len       = slot_len_ff[head_ff];
   assign rpos_inc       = mrq_pkg::len_type'(rpos_ff) + mrq_pkg::len_type'(1);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      wpos_in     = wpos_ff;
      rpos_in     = rpos_ff;
      overlong_in = overlong_ff;
      len_wr      = 1'b0;
      q_entry     = '0;
      q_entry.status = mrq_pkg::STATUS_OK;

      case (req_chan.command)
         mrq_pkg::CMD_CLEAR: begin
            head_in     = '0;
            tail_in     = '0;
            count_in    = '0;
            wpos_in     = '0;
            rpos_in     = '0;
            overlong_in = 1'b0;
         end
         mrq_pkg::CMD_PUSH: begin
            if (overlong_ff || (wpos_ff >= mrq_pkg::len_type'(mrq_pkg::MAX_LEN))) begin
               // Overlong message: swallow bytes until the last one rejects it.
               if (req_chan.data_in_last) begin
                  overlong_in    = 1'b0;
                  wpos_in        = '0;
                  q_entry.status = mrq_pkg::STATUS_TOO_LONG;
               end else begin
                  overlong_in = 1'b1;
               end
            end else begin
               q_entry.mem_wr = 1'b1;
               q_entry.addr   = mrq_pkg::slot_addr(tail_ff, mrq_pkg::pos_type'(wpos_ff));
               q_entry.wdata  = req_chan.data_in;
               wpos_in        = wpos_ff + mrq_pkg::len_type'(1);
               if (req_chan.data_in_last) begin
                  len_wr         = 1'b1;
                  wpos_in        = '0;
                  q_entry.status = mrq_pkg::STATUS_COMMITTED;
                  tail_in        = mrq_pkg::ring_next(tail_ff);
                  if (count_ff >= mrq_pkg::count_type'(mrq_pkg::SLOTS)) begin
                     // Full: the oldest message goes, count stays the same.
                     head_in = mrq_pkg::ring_next(head_ff);
                     rpos_in = '0;
                  end else begin
                     count_in = count_ff + mrq_pkg::count_type'(1);
                  end
               end
            end
         end
         mrq_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               q_entry.status = mrq_pkg::STATUS_EMPTY;
            end else begin
               q_entry.mlen = mrq_pkg::mlen_type'(head_len);
               if ((rpos_ff == '0) && (mrq_pkg::CMP_W'(head_len) >
                                       mrq_pkg::CMP_W'(req_chan.out_capacity))) begin
                  q_entry.status = mrq_pkg::STATUS_TOO_SMALL;
               end else begin
                  q_entry.mem_rd = 1'b1;
                  q_entry.addr   = mrq_pkg::slot_addr(head_ff, rpos_ff);
                  if (rpos_inc >= head_len) begin
                     q_entry.last = 1'b1;
                     rpos_in      = '0;
                     head_in      = mrq_pkg::ring_next(head_ff);
                     count_in     = count_ff - mrq_pkg::count_type'(1);
                  end else begin
                     rpos_in = mrq_pkg::pos_type'(rpos_inc);
                  end
               end
            end
         end
         default: begin
         end
      endcase

      q_entry.qcount = mrq_pkg::qcount_type'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         wpos_ff     <= '0;
         rpos_ff     <= '0;
         overlong_ff <= 1'b0;
      end else if (accept) begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         wpos_ff     <= wpos_in;
         rpos_ff     <= rpos_in;
         overlong_ff <= overlong_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && len_wr) begin
         slot_len_ff[tail_ff] <= wpos_ff + mrq_pkg::len_type'(1);
      end
   end

endmodule

FILE: rtl/mrq_fifo.sv
// Short queue of classified transactions between the front and back ends.
// Depends on mrq_pkg.
`timescale 1ns / 1ps

module mrq_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     push_ready,
   input  mrq_pkg::queue_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output mrq_pkg::queue_entry_type pop_entry
);

   mrq_pkg::queue_entry_type entry_ff [mrq_pkg::QUEUE_DEPTH];
   logic [mrq_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mrq_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mrq_pkg::QFILL_W-1:0] fill_ff, fill_in;
   logic                        do_pop;

   assign push_ready = (fill_ff != mrq_pkg::QFILL_W'(mrq_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mrq_pkg::QPTR_W'(mrq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mrq_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mrq_pkg::QPTR_W'(mrq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mrq_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + mrq_pkg::QFILL_W'(1);
      end else if (do_pop && !push) begin
         fill_in = fill_ff - mrq_pkg::QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/mrq_back.sv
// Back end: carries out the byte store access of each transaction and holds
// the result in the output register. Depends on mrq_pkg, mrq_if.
`timescale 1ns / 1ps

module mrq_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_ready,
   input  mrq_pkg::queue_entry_type q_entry,
   mrq_rsp_if.source                rsp_chan
);

   mrq_pkg::byte_type        byte_store_ff [mrq_pkg::RING * mrq_pkg::MAX_LEN];
   mrq_pkg::byte_type        rdata_ff;
   logic                     rsp_valid_ff;
   mrq_pkg::queue_entry_type rsp_entry_ff;
   logic                     take;

   assign q_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take    = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (take && q_entry.mem_wr) begin
         byte_store_ff[q_entry.addr] <= q_entry.wdata;
      end
      if (take && q_entry.mem_rd) begin
         rdata_ff <= byte_store_ff[q_entry.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_ready) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_entry_ff <= q_entry;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_entry_ff.status;
   assign rsp_chan.data_out       = rsp_entry_ff.mem_rd ? rdata_ff : '0;
   assign rsp_chan.data_out_last  = rsp_entry_ff.last;
   assign rsp_chan.message_length = rsp_entry_ff.mlen;
   assign rsp_chan.queue_count    = rsp_entry_ff.qcount;

endmodule

FILE: rtl/message_ring_queue_drop_oldest.sv
// Ring queue of variable-length byte messages with drop-oldest overflow.
// Each transaction is registered in the queue, then in the output register.
// Throughput: one transaction per cycle while the response side keeps up, set by
// the byte store, which the back end accesses at most once for each transaction.
// Reset (synchronous, active high) clears the ring pointers, counts and queue;
// the byte store and length table are left unset and need no pass.
`timescale 1ns / 1ps

// The block is split in two halves joined by a two-entry queue.
//
// The front end holds all of the ring bookkeeping: head and tail slots, the
// message count, the write position of the open message, the read position of
// the head message and the overlong flag, plus the table of committed message
// lengths. Every command is resolved there in the cycle it is accepted, so the
// next transaction always sees up-to-date bookkeeping. What remains is at most
// one byte store access, which travels down the queue together with the
// already computed response fields.
//
// The back end owns the byte store. It performs the writes and reads in the
// same order as the front end issued them, so a read always sees every write
// that came before it. The read data is registered alongside the response,
// and the output register holds both while the response side stalls.
//
// The queue lets the request side keep going while a response waits to be
// taken, and lets the back end drain while no new request arrives.

module message_ring_queue_drop_oldest (
   input  logic       clock,
   input  logic       reset,
   mrq_req_if.sink    req_chan,
   mrq_rsp_if.source  rsp_chan
);

   logic                     front_push;
   logic                     front_ready;
   mrq_pkg::queue_entry_type front_entry;
   logic                     back_valid;
   logic                     back_ready;
   mrq_pkg::queue_entry_type back_entry;

   mrq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_push   (front_push),
      .q_ready  (front_ready),
      .q_entry  (front_entry)
   );

   mrq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_ready (front_ready),
      .push_entry (front_entry),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_entry  (back_entry)
   );

   mrq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (back_valid),
      .q_ready  (back_ready),
      .q_entry  (back_entry),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: tb/sv/message_queue_checker.sv
// Checker for the message ring queue: watches both channels, predicts each response
// from its own model of the ring and compares field by field.
// Depends on mrq_pkg for codes and sizes and on mrq_if for the channel interfaces.
`timescale 1ns / 1ps

module message_queue_checker (
   input  logic clock,
   input  logic reset,
   mrq_req_if   req_mon,
   mrq_rsp_if   rsp_mon,
   output int   failures,
   output int   outstanding
);
   import mrq_pkg::*;

   typedef struct packed {
      status_type status;
      byte_type   data_out;
      logic       data_out_last;
      mlen_type   message_length;
      qcount_type queue_count;
   } response_type;

   // Predicted ring state.
   byte_type   byte_mem [RING*MAX_LEN];
   logic [8:0] msg_len [RING];
   logic [4:0] head_q, tail_q, held_q;
   logic [8:0] wr_pos, rd_pos;
   logic       overlong;

   response_type expected_q [$];
   response_type want, got;
   int           errors = 0;

   function automatic logic [4:0] next_slot(input logic [4:0] s);
      return 5'((int'(s) + 1) % RING);
   endfunction

   function automatic status_type predict_push(input byte_type b, input logic is_last);
      int t;
      t = int'(tail_q) % RING;
      if (!overlong && wr_pos >= MAX_LEN) overlong = 1'b1;
      if (overlong) begin
         if (!is_last) return STATUS_OK;
         overlong = 1'b0;
         wr_pos   = '0;
         return STATUS_TOO_LONG;
      end
      byte_mem[t*MAX_LEN + int'(wr_pos)] = b;
      wr_pos = wr_pos + 9'd1;
      if (!is_last) return STATUS_OK;
      msg_len[t] = wr_pos;
      wr_pos     = '0;
      // A full ring loses its oldest message, together with any partial read of it.
      if (held_q >= SLOTS) begin
         head_q = next_slot(head_q);
         held_q = held_q - 5'd1;
         rd_pos = '0;
      end
      tail_q = next_slot(tail_q);
      held_q = held_q + 5'd1;
      return STATUS_COMMITTED;
   endfunction

   function automatic response_type predict_response(input command_type cmd,
                                                     input byte_type din,
                                                     input logic din_last,
                                                     input logic [8:0] cap);
      response_type r;
      int           hlen;
      int           pos;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            head_q   = '0;
            tail_q   = '0;
            held_q   = '0;
            wr_pos   = '0;
            rd_pos   = '0;
            overlong = 1'b0;
         end
         CMD_PUSH: r.status = predict_push(din, din_last);
         CMD_POP: begin
            if (held_q == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               hlen             = int'(msg_len[head_q]);
               r.message_length = hlen[8:0];
               if (rd_pos == 0 && hlen > int'(cap)) begin
                  r.status = STATUS_TOO_SMALL;
               end else begin
                  pos        = int'(rd_pos) % MAX_LEN;
                  r.data_out = byte_mem[int'(head_q)*MAX_LEN + pos];
                  rd_pos     = 9'(pos + 1);
                  if (int'(rd_pos) >= hlen) begin
                     r.data_out_last = 1'b1;
                     rd_pos          = '0;
                     head_q          = next_slot(head_q);
                     held_q          = held_q - 5'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.queue_count = held_q;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [8:0] exp_val,
                              input logic [8:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   // Responses are checked before the request of the same edge is predicted, since
   // no response can leave in the cycle its request is taken.
   always @(posedge clock) begin
      if (reset) begin
         head_q   = '0;
         tail_q   = '0;
         held_q   = '0;
         wr_pos   = '0;
         rd_pos   = '0;
         overlong = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.data_out, rsp_mon.data_out_last,
                    rsp_mon.message_length, rsp_mon.queue_count};
            if (expected_q.size() == 0) begin
               $error("response transaction arrived with no request outstanding");
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", 9'(want.status), 9'(got.status));
               check_field("data_out", 9'(want.data_out), 9'(got.data_out));
               check_field("data_out_last", 9'(want.data_out_last), 9'(got.data_out_last));
               check_field("message_length", want.message_length, got.message_length);
               check_field("queue_count", 9'(want.queue_count), 9'(got.queue_count));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(predict_response(req_mon.command, req_mon.data_in,
                                                  req_mon.data_in_last,
                                                  req_mon.out_capacity));
         end
      end
      outstanding <= expected_q.size();
      failures    <= errors;
   end

endmodule

FILE: tb/sv/tb_message_ring_queue_drop_oldest.sv
// Top of the message ring queue testbench: clock, reset, stimulus, flow control and verdict.
// Depends on mrq_pkg, mrq_if, the block itself and message_queue_checker.
`timescale 1ns / 1ps

module tb_message_ring_queue_drop_oldest;
   import mrq_pkg::*;

   // The receiver holds off this long once, so that the block fills and stalls its input.
   localparam int HOLD_OFF_CYCLES = 150;
   // Cycles without any transaction on either channel before the run is abandoned.
   // The longest legitimate quiet stretch is the hold-off above.
   localparam int WATCHDOG_LIMIT  = 2000;
   // Random transactions per idling phase.
   localparam int PHASE_ITEMS     = 20;

   logic clock;
   logic reset;

   mrq_req_if req_ch ();
   mrq_rsp_if rsp_ch ();

   int failures;
   int outstanding;
   int items_sent = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_off_req = 1'b0;

   message_ring_queue_drop_oldest dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch)
   );

   message_queue_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one request transaction and returns once it has been accepted. Valid is
   // left high afterwards so that back-to-back transactions need no gap; it is only
   // lowered when the sender decides to idle or waits for a drain, which always happens at a later edge.
   task automatic send_request(input command_type cmd, input byte_type din,
                               input logic din_last, input logic [8:0] cap);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.data_in      <= din;
      req_ch.data_in_last <= din_last;
      req_ch.out_capacity <= cap;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Reader capacity: mostly the largest, so that messages drain, sometimes anything.
   function automatic logic [8:0] rand_cap();
      if ($urandom_range(0, 99) < 75) return 9'd256;
      return 9'($urandom_range(0, 256));
   endfunction

   // Streams one message of the given length with random bytes. The capacity field is
   // meaningless on a push and is randomised so that its bits still toggle.
   task automatic push_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_request(CMD_PUSH, byte_type'($urandom), (i == len - 1),
                      9'($urandom_range(0, 256)));
      end
   endtask

   // Pops a number of bytes at one reader capacity; the data fields are don't-care.
   task automatic pop_bytes(input int n, input logic [8:0] cap);
      for (int i = 0; i < n; i++) begin
         send_request(CMD_POP, byte_type'($urandom), logic'($urandom_range(0, 1)), cap);
      end
   endtask

   // Stops offering and waits until every predicted response has been taken. The count is
   // only checked after an edge has passed, so that a transaction accepted at the last edge is counted.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Response side flow control. A hold-off request from the stimulus makes the
   // receiver refuse responses for a fixed stretch, counted here.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int target;
      int pick;
      int len;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.command      <= CMD_QUERY;
      req_ch.data_in      <= '0;
      req_ch.data_in_last <= 1'b0;
      req_ch.out_capacity <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty queue, byte extremes, capacity extremes, the too-small
      // refusal that leaves the message in place, capacity being ignored once reading
      // has begun, and a clear that abandons an open message.
      send_request(CMD_QUERY, 8'h00, 1'b0, 9'd0);
      send_request(CMD_POP, 8'hFF, 1'b1, 9'd256);
      send_request(CMD_PUSH, 8'h00, 1'b1, 9'd0);
      send_request(CMD_PUSH, 8'hFF, 1'b0, 9'd256);
      send_request(CMD_PUSH, 8'hA5, 1'b1, 9'd256);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd0);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd1);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd1);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd2);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd0);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd256);
      send_request(CMD_PUSH, 8'h5A, 1'b0, 9'd0);
      send_request(CMD_PUSH, 8'h3C, 1'b1, 9'd0);
      send_request(CMD_PUSH, 8'h77, 1'b0, 9'd0);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd256);
      send_request(CMD_PUSH, 8'h81, 1'b0, 9'd0);
      send_request(CMD_CLEAR, 8'hFF, 1'b1, 9'd256);
      send_request(CMD_QUERY, 8'hFF, 1'b1, 9'd256);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd256);
      send_request(CMD_PUSH, 8'h11, 1'b1, 9'd0);
      send_request(CMD_POP, 8'h00, 1'b0, 9'd256);

      // Drop of the oldest message while it is partly read: the read position must
      // return to the start of the new head.
      push_message(2);
      pop_bytes(1, 9'd256);
      repeat (SLOTS) push_message(1);
      pop_bytes(3, 9'd256);
      send_request(CMD_CLEAR, 8'h00, 1'b0, 9'd0);

      // A message of exactly the maximum length commits; one byte short of capacity
      // refuses it, full capacity starts reading it, and a clear drops the rest.
      push_message(MAX_LEN);
      pop_bytes(1, 9'(MAX_LEN - 1));
      pop_bytes(2, 9'd256);
      send_request(CMD_CLEAR, 8'h00, 1'b0, 9'd0);

      // An overlong message is rejected whole, and the next message starts cleanly.
      push_message(MAX_LEN + 1);
      send_request(CMD_QUERY, 8'h00, 1'b0, 9'd0);
      push_message(3);
      pop_bytes(4, 9'd256);

      // Clear while the head is partly read.
      push_message(4);
      pop_bytes(2, 9'd256);
      send_request(CMD_CLEAR, 8'h00, 1'b0, 9'd0);
      wait_for_drain();

      // Random part in four idling phases. Most of it is whole messages and pops of a
      // few bytes; bursts of short pushes run the ring into drop-oldest; the rest is
      // queries, clears and arbitrary commands.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
            default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
         endcase
         if (ph == 0) begin
            // Back pressure: the receiver holds off while short messages keep coming,
            // so the block fills up and refuses further requests for a while.
            hold_off_req = 1'b1;
            repeat (15) push_message($urandom_range(1, 3));
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
               len = $urandom_range(0, 99);
               if (len < 90)
                  push_message($urandom_range(1, 6));
               else if (len < 99)
                  push_message($urandom_range(7, 30));
               else
                  push_message($urandom_range(31, 60));
            end else if (pick < 70) begin
               pop_bytes($urandom_range(1, 8), rand_cap());
            end else if (pick < 78) begin
               repeat ($urandom_range(14, 18)) push_message($urandom_range(1, 3));
            end else if (pick < 86) begin
               send_request(CMD_QUERY, byte_type'($urandom), logic'($urandom_range(0, 1)),
                            rand_cap());
            end else if (pick < 90) begin
               send_request(CMD_CLEAR, byte_type'($urandom), logic'($urandom_range(0, 1)),
                            rand_cap());
            end else begin
               send_request(command_type'($urandom_range(0, 3)), byte_type'($urandom),
                            logic'($urandom_range(0, 1)), 9'($urandom_range(0, 256)));
            end
         end
         // The sender pauses here until every response of the phase has arrived.
         wait_for_drain();
      end

      // Allow for a stray response before the verdict.
      repeat (16) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
